// ===== src/assert_macros.svh =====
// Assertion macros for the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DKUC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define DKUC_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define DKUC_ASSERT(label, clk, rst_n, prop)
`define DKUC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== src/dkuc_pkg.sv =====
// Package: sizes, codes and entry layout of the digest-keyed unique counter
`default_nettype none
package dkuc_pkg;
	localparam int CAPACITY = 1024;
	localparam int BUCKETS  = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int BKT_W    = $clog2(BUCKETS);
	localparam int LIMIT_W  = 11;
	localparam int CMP_W    = (LIMIT_W > CNT_W) ? LIMIT_W : CNT_W;
	localparam int DIG_W    = 64;
	localparam int COUNT_W  = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_GET = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [DIG_W-1:0]   digest_high;
		logic [DIG_W-1:0]   digest_low;
		logic               next_end;
		logic [IDX_W-1:0]   next;
		logic [COUNT_W-1:0] count;
	} entry_t;
endpackage
`default_nettype wire

// ===== src/dkuc_req_if.sv =====
// Request channel: command and 128-bit digest
`default_nettype none
interface dkuc_req_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [dkuc_pkg::DIG_W-1:0]  digest_high;
	logic [dkuc_pkg::DIG_W-1:0]  digest_low;

	modport source (output valid, command, digest_high, digest_low, input ready);
	modport sink (input valid, command, digest_high, digest_low, output ready);
endinterface
`default_nettype wire

// ===== src/dkuc_rsp_if.sv =====
// Response channel: status, found flag and occurrence count
`default_nettype none
interface dkuc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic                          found;
	logic [dkuc_pkg::COUNT_W-1:0]  match_count;

	modport source (output valid, status, found, match_count, input ready);
	modport sink (input valid, status, found, match_count, output ready);
endinterface
`default_nettype wire

// ===== src/digest_keyed_unique_counter_top.sv =====
// Digest-keyed unique counter: chained hash table over an entry memory
//
//   channel    dir   payload
//   request    in    command, digest_high, digest_low
//   response   out   status, found, match_count
//   cfg        in    cfg_we, cfg_wdata (entry_limit)
//
// One transaction at a time. An ADD to a full table is answered from the head state
// without a chain walk; otherwise the walk does one entry-memory read per cycle.
// Reset clears bucket valid flags and the entry count at once; no sweep.
// A new request is taken while the previous response waits in its register.
`default_nettype none
`include "assert_macros.svh"
module digest_keyed_unique_counter_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	dkuc_req_if.sink                           request,
	dkuc_rsp_if.source                         response,
	input  wire logic                          cfg_we,
	input  wire logic [dkuc_pkg::LIMIT_W-1:0]  cfg_wdata
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HEAD = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	logic [1:0]                       state_q, state_d;
	logic [dkuc_pkg::CNT_W-1:0]       uniq_q;
	logic [dkuc_pkg::BUCKETS-1:0]     bvalid_q;
	logic [dkuc_pkg::LIMIT_W-1:0]     limit_q;

	logic                             cmd_q;
	logic [dkuc_pkg::DIG_W-1:0]       dh_q, dl_q;
	logic [dkuc_pkg::IDX_W-1:0]       slot_q, slot_d;

	logic                             res_status_q, res_status_d;
	logic                             res_found_q, res_found_d;
	logic [dkuc_pkg::COUNT_W-1:0]     res_count_q, res_count_d;

	logic                             out_valid_q;
	logic                             out_status_q, out_found_q;
	logic [dkuc_pkg::COUNT_W-1:0]     out_count_q;

	dkuc_pkg::entry_t                 ent_mem [dkuc_pkg::CAPACITY];
	dkuc_pkg::entry_t                 ent_rd_q, ent_wd;
	logic                             ent_we, ent_re;
	logic [dkuc_pkg::IDX_W-1:0]       ent_wa, ent_ra;

	logic [dkuc_pkg::IDX_W-1:0]       head_mem [dkuc_pkg::BUCKETS];
	logic [dkuc_pkg::IDX_W-1:0]       head_rd_q;
	logic                             head_we;

	logic                             accept, out_load, full, match, do_hit, do_miss;
	logic [dkuc_pkg::BKT_W-1:0]       bkt;
	logic [dkuc_pkg::COUNT_W-1:0]     cnt_inc;

	assign accept   = request.valid && request.ready;
	assign request.ready = (state_q == ST_IDLE);
	assign bkt      = dh_q[dkuc_pkg::DIG_W-1 -: dkuc_pkg::BKT_W];
	assign full     = (cmd_q == dkuc_pkg::CMD_ADD) &&
		((dkuc_pkg::CMP_W'(uniq_q) >= dkuc_pkg::CMP_W'(limit_q)) ||
		 (uniq_q == dkuc_pkg::CNT_W'(dkuc_pkg::CAPACITY)));
	assign match    = (ent_rd_q.digest_high == dh_q) && (ent_rd_q.digest_low == dl_q);
	assign cnt_inc  = (ent_rd_q.count == '1) ? ent_rd_q.count :
		ent_rd_q.count + dkuc_pkg::COUNT_W'(1);
	assign out_load = (state_q == ST_RESP) && (!out_valid_q || response.ready);

	always_comb begin
		state_d      = state_q;
		slot_d       = slot_q;
		res_status_d = res_status_q;
		res_found_d  = res_found_q;
		res_count_d  = res_count_q;
		ent_re       = 1'b0;
		ent_ra       = head_rd_q;
		do_hit       = 1'b0;
		do_miss      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (full) begin
					res_status_d = dkuc_pkg::STATUS_FULL;
					res_found_d  = 1'b0;
					res_count_d  = '0;
					state_d      = ST_RESP;
				end else if (!bvalid_q[bkt]) begin
					do_miss = 1'b1;
				end else begin
					ent_re  = 1'b1;
					ent_ra  = head_rd_q;
					slot_d  = head_rd_q;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (match) begin
					do_hit = 1'b1;
				end else if (ent_rd_q.next_end) begin
					do_miss = 1'b1;
				end else begin
					ent_re = 1'b1;
					ent_ra = ent_rd_q.next;
					slot_d = ent_rd_q.next;
				end
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (do_hit || do_miss) begin
			state_d      = ST_RESP;
			res_status_d = dkuc_pkg::STATUS_OK;
			res_found_d  = do_hit;
			if (do_hit) begin
				res_count_d = (cmd_q == dkuc_pkg::CMD_ADD) ? cnt_inc : ent_rd_q.count;
			end else begin
				res_count_d = (cmd_q == dkuc_pkg::CMD_ADD) ? dkuc_pkg::COUNT_W'(1) : '0;
			end
		end
	end

	// entry write on ADD only: count bump on hit, new chain head on miss
	always_comb begin
		ent_we  = (do_hit || do_miss) && (cmd_q == dkuc_pkg::CMD_ADD);
		head_we = do_miss && (cmd_q == dkuc_pkg::CMD_ADD);
		ent_wa  = do_hit ? slot_q : uniq_q[dkuc_pkg::IDX_W-1:0];
		ent_wd  = ent_rd_q;
		ent_wd.count = cnt_inc;
		if (!do_hit) begin
			ent_wd.digest_high = dh_q;
			ent_wd.digest_low  = dl_q;
			ent_wd.next_end    = !bvalid_q[bkt];
			ent_wd.next        = head_rd_q;
			ent_wd.count       = dkuc_pkg::COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		if (ent_re) begin
			ent_rd_q <= ent_mem[ent_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[bkt] <= uniq_q[dkuc_pkg::IDX_W-1:0];
		end
		if (accept) begin
			head_rd_q <= head_mem[request.digest_high[dkuc_pkg::DIG_W-1 -: dkuc_pkg::BKT_W]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			uniq_q      <= '0;
			bvalid_q    <= '0;
			limit_q     <= dkuc_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (head_we) begin
				bvalid_q[bkt] <= 1'b1;
				uniq_q        <= uniq_q + dkuc_pkg::CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= request.command;
			dh_q  <= request.digest_high;
			dl_q  <= request.digest_low;
		end
		slot_q       <= slot_d;
		res_status_q <= res_status_d;
		res_found_q  <= res_found_d;
		res_count_q  <= res_count_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_count_q  <= res_count_q;
		end
	end

	assign response.valid       = out_valid_q;
	assign response.status      = out_status_q;
	assign response.found       = out_found_q;
	assign response.match_count = out_count_q;

	`DKUC_ASSERT(a_uniq_bound, clk, arst_n, uniq_q <= dkuc_pkg::CNT_W'(dkuc_pkg::CAPACITY))
	`DKUC_ASSERT(a_accept_leaves_idle, clk, arst_n, accept |=> state_q == ST_HEAD)
	`DKUC_ASSERT(a_uniq_only_on_add, clk, arst_n, head_we |-> cmd_q == dkuc_pkg::CMD_ADD && !full)
	`DKUC_ASSERT(a_write_in_range, clk, arst_n, ent_we |-> dkuc_pkg::CNT_W'(ent_wa) <= uniq_q)
	`DKUC_ASSERT(a_resp_loads_out, clk, arst_n, out_load |=> out_valid_q && state_q == ST_IDLE)
endmodule
`default_nettype wire
